>>> hdl/sfir_pkg.sv
// shared types and constants of the switchable fir filter with level clamp
package sfir_pkg;

    localparam int DELAY_TAPS = 4;
    localparam int SAMPLE_W   = 10;
    localparam int LEVEL_W    = 8;
    localparam int SUM_W      = 14;

    typedef logic [SAMPLE_W-1:0]     sample_t;
    typedef logic [LEVEL_W-1:0]      level_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    // high-pass weights, newest sample first
    localparam int HP_WEIGHTS [DELAY_TAPS+1] = '{1, 2, -6, 2, 1};

    localparam sample_t HIST_RESET  = sample_t'(512);
    localparam sample_t SAMPLE_MAX  = sample_t'(1023);
    localparam level_t  LEVEL_RESET = level_t'(100);
    localparam level_t  LEVEL_FLOOR = level_t'(5);
    localparam level_t  LEVEL_DN_LO = level_t'(7);
    localparam level_t  LEVEL_STEP  = level_t'(2);
    localparam level_t  LEVEL_TOP   = level_t'(250);
    localparam level_t  LEVEL_CEIL  = level_t'(255);

    // divide by DELAY_TAPS+1 through a reciprocal: 52429 / 2^18 is exact for sums below 2^18
    localparam int RECIP_W   = 16;
    localparam int AVG_SHIFT = 18;
    localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(52429);

    localparam logic FILTER_AVG = 1'b0;
    localparam logic FILTER_HP  = 1'b1;

endpackage

>>> hdl/switchable_fir_with_clamp.sv
// top level: five-tap fir with selectable average or high-pass mode and a clamped compare level
// an accepted input transaction passes the tap-sum register, then the output register, to m_tvalid
// throughput: one transaction per cycle unless m_tready back-pressure stalls it, through the
// tap chain and the two registered stages (tap sum, then scale and clamp)
// reset: synchronous on aresetn low; history cells load 512, mode is average, level is 100
module switchable_fir_with_clamp (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // sample[9:0], down_press[10], toggle_press[11], up_press[12]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // raw_sample[9:0], filtered[19:10], compare_level[27:20]
    output logic [0:0]  m_tuser    // filter_mode[0]
);

    localparam int NT = sfir_pkg::DELAY_TAPS;

    logic s_accept;
    logic a_ready;
    logic out_ready;

    sfir_pkg::sample_t s_sample;
    logic              s_down;
    logic              s_toggle;
    logic              s_up;

    logic              mode_reg;
    logic              mode_next;
    sfir_pkg::level_t  level_reg;
    sfir_pkg::level_t  level_next;
    sfir_pkg::level_t  level_dn;

    sfir_pkg::sample_t tap_chain [NT+1];
    sfir_pkg::sum_t    sum_chain [NT+1];

    logic              a_valid_reg;
    sfir_pkg::sum_t    a_sum_reg;
    logic              a_mode_reg;
    sfir_pkg::sample_t a_raw_reg;
    sfir_pkg::level_t  a_level_reg;

    sfir_pkg::sample_t post_filtered;

    logic              m_valid_reg;
    sfir_pkg::sample_t m_raw_reg;
    sfir_pkg::sample_t m_filt_reg;
    sfir_pkg::level_t  m_level_reg;
    logic              m_mode_reg;

    assign s_sample = s_tdata[sfir_pkg::SAMPLE_W-1:0];
    assign s_down   = s_tdata[10];
    assign s_toggle = s_tdata[11];
    assign s_up     = s_tdata[12];

    assign out_ready = !m_valid_reg || m_tready;
    assign a_ready   = !a_valid_reg || out_ready;
    assign s_tready  = a_ready;
    assign s_accept  = s_tvalid && a_ready;

    // presses apply in the order down, toggle, up
    always_comb begin
        if (s_down) begin
            if (level_reg <= sfir_pkg::LEVEL_DN_LO) begin
                level_dn = sfir_pkg::LEVEL_FLOOR;
            end else begin
                level_dn = level_reg - sfir_pkg::LEVEL_STEP;
            end
        end else begin
            level_dn = level_reg;
        end
        if (s_up) begin
            if (({1'b0, level_dn} + {1'b0, sfir_pkg::LEVEL_STEP}) > {1'b0, sfir_pkg::LEVEL_TOP}) begin
                level_next = sfir_pkg::LEVEL_CEIL;
            end else begin
                level_next = level_dn + sfir_pkg::LEVEL_STEP;
            end
        end else begin
            level_next = level_dn;
        end
        mode_next = mode_reg ^ s_toggle;
    end

    // newest sample always has weight one in both modes
    assign tap_chain[0] = s_sample;
    assign sum_chain[0] = sfir_pkg::sum_t'({1'b0, s_sample});

    for (genvar i = 0; i < NT; i++) begin : g_cell
        sfir_tap_cell #(
            .HP_WEIGHT (sfir_pkg::HP_WEIGHTS[i+1])
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .shift_en   (s_accept),
            .hp_mode    (mode_next),
            .sample_in  (tap_chain[i]),
            .sum_in     (sum_chain[i]),
            .sample_out (tap_chain[i+1]),
            .sum_out    (sum_chain[i+1])
        );
    end

    sfir_post u_post (
        .sum      (a_sum_reg),
        .hp_mode  (a_mode_reg),
        .filtered (post_filtered)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= sfir_pkg::FILTER_AVG;
            level_reg   <= sfir_pkg::LEVEL_RESET;
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                mode_reg  <= mode_next;
                level_reg <= level_next;
            end
            if (a_ready) begin
                a_valid_reg <= s_tvalid;
            end
            if (out_ready) begin
                m_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_sum_reg   <= sum_chain[NT];
            a_mode_reg  <= mode_next;
            a_raw_reg   <= s_sample;
            a_level_reg <= level_next;
        end
        if (out_ready && a_valid_reg) begin
            m_raw_reg   <= a_raw_reg;
            m_filt_reg  <= post_filtered;
            m_level_reg <= a_level_reg;
            m_mode_reg  <= a_mode_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, m_level_reg, m_filt_reg, m_raw_reg};
    assign m_tuser  = m_mode_reg;

    level_floor_a : assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg >= sfir_pkg::LEVEL_FLOOR)
        else $error("compare level below floor");

    toggle_flips_a : assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_toggle |=> mode_reg != $past(mode_reg))
        else $error("toggle press did not swap filter mode");

    history_shift_a : assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> tap_chain[1] == $past(s_sample))
        else $error("newest history cell did not take the accepted sample");

    stage_hold_a : assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && !out_ready |=> a_valid_reg && $stable(a_sum_reg))
        else $error("filter stage lost a transaction under back-pressure");

endmodule

>>> hdl/sfir_tap_cell.sv
// one delay cell of the filter chain: holds one past sample and adds its weighted term
module sfir_tap_cell #(
    parameter int HP_WEIGHT = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             shift_en,
    input  logic             hp_mode,
    input  sfir_pkg::sample_t sample_in,
    input  sfir_pkg::sum_t    sum_in,
    output sfir_pkg::sample_t sample_out,
    output sfir_pkg::sum_t    sum_out
);

    localparam sfir_pkg::sum_t WEIGHT_S = sfir_pkg::sum_t'(HP_WEIGHT);

    sfir_pkg::sample_t sample_reg;
    sfir_pkg::sum_t    term;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= sfir_pkg::HIST_RESET;
        end else if (shift_en) begin
            sample_reg <= sample_in;
        end
    end

    always_comb begin
        term = sfir_pkg::sum_t'($signed({1'b0, sample_reg}));
        if (hp_mode == sfir_pkg::FILTER_HP) begin
            sum_out = sum_in + sfir_pkg::sum_t'(term * WEIGHT_S);
        end else begin
            sum_out = sum_in + term;
        end
    end

    assign sample_out = sample_reg;

endmodule

>>> hdl/sfir_post.sv
// scaling and clamping of the tap sum: divide by five or clamp the high-pass sum
module sfir_post (
    input  sfir_pkg::sum_t    sum,
    input  logic              hp_mode,
    output sfir_pkg::sample_t filtered
);

    localparam int PROD_W = sfir_pkg::SUM_W - 1 + sfir_pkg::RECIP_W;

    logic [PROD_W-1:0]             prod;
    logic [sfir_pkg::SAMPLE_W:0]   quot;

    always_comb begin
        // average sums are never negative, so the sign bit is dropped
        prod = PROD_W'(sum[sfir_pkg::SUM_W-2:0]) * PROD_W'(sfir_pkg::AVG_RECIP);
        quot = prod[sfir_pkg::AVG_SHIFT +: sfir_pkg::SAMPLE_W+1];
        if (hp_mode == sfir_pkg::FILTER_HP) begin
            if (sum < 0) begin
                filtered = '0;
            end else if (sum > sfir_pkg::sum_t'({1'b0, sfir_pkg::SAMPLE_MAX})) begin
                filtered = sfir_pkg::SAMPLE_MAX;
            end else begin
                filtered = sum[sfir_pkg::SAMPLE_W-1:0];
            end
        end else begin
            if (quot > {1'b0, sfir_pkg::SAMPLE_MAX}) begin
                filtered = sfir_pkg::SAMPLE_MAX;
            end else begin
                filtered = quot[sfir_pkg::SAMPLE_W-1:0];
            end
        end
    end

endmodule

>>> tb/switchable_fir_with_clamp_test.sv
// self-checking testbench for the switchable five-tap fir with clamped compare level
`timescale 1ns / 100ps

module switchable_fir_with_clamp_test;

    localparam int NTAPS       = sfir_pkg::DELAY_TAPS + 1;
    localparam int STALL_LEN   = 300;
    localparam int BLOCK_LEN   = 80;
    localparam int FIELD_MAX   = 1023;
    localparam int LEVEL_MARGIN = 250;

    // own copy of the tap weights, newest sample first
    localparam int TAP_WEIGHTS [NTAPS] = '{1, 2, -6, 2, 1};

    // press bias of a random block
    localparam int BIAS_NONE = 0;
    localparam int BIAS_DOWN = 1;
    localparam int BIAS_UP   = 2;

    typedef struct {
        sfir_pkg::sample_t raw;
        sfir_pkg::sample_t filtered;
        sfir_pkg::level_t  level;
        logic              mode;
    } fir_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // sample[9:0], down_press[10], toggle_press[11], up_press[12]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // raw_sample[9:0], filtered[19:10], compare_level[27:20]
    logic [0:0]  m_tuser;          // filter_mode[0]

    // predictor state
    sfir_pkg::sample_t tap_hist [sfir_pkg::DELAY_TAPS];
    sfir_pkg::level_t  cmp_level;
    logic              fir_mode;

    logic [15:0] pending_items [$];
    fir_result_t fir_expected [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_requests = 0;
    int mismatches = 0;
    int results_seen = 0;
    int floor_items = 0;
    int ceil_items = 0;
    int hp_clamped = 0;
    int hp_items = 0;

    switchable_fir_with_clamp dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic clear_filter_state();
        for (int i = 0; i < sfir_pkg::DELAY_TAPS; i++) tap_hist[i] = sfir_pkg::HIST_RESET;
        cmp_level = sfir_pkg::LEVEL_RESET;
        fir_mode  = sfir_pkg::FILTER_AVG;
    endtask

    // apply presses, filter the new sample with the history, then shift it in
    function automatic fir_result_t filter_step(input logic [15:0] word);
        sfir_pkg::sample_t x;
        int                acc;
        fir_result_t       r;
        x = word[9:0];
        if (word[10]) cmp_level = (cmp_level <= sfir_pkg::LEVEL_DN_LO)
                                  ? sfir_pkg::LEVEL_FLOOR
                                  : cmp_level - sfir_pkg::LEVEL_STEP;
        if (word[11]) fir_mode = ~fir_mode;
        if (word[12]) cmp_level = (int'(cmp_level) + int'(sfir_pkg::LEVEL_STEP) > LEVEL_MARGIN)
                                  ? sfir_pkg::LEVEL_CEIL
                                  : cmp_level + sfir_pkg::LEVEL_STEP;
        if (fir_mode == sfir_pkg::FILTER_AVG) begin
            acc = int'(x);
            for (int i = 0; i < sfir_pkg::DELAY_TAPS; i++) acc += int'(tap_hist[i]);
            acc = acc / NTAPS;
        end else begin
            acc = int'(x) * TAP_WEIGHTS[0];
            for (int i = 0; i < sfir_pkg::DELAY_TAPS; i++)
                acc += int'(tap_hist[i]) * TAP_WEIGHTS[i+1];
            hp_items++;
            if (acc < 0 || acc > FIELD_MAX) hp_clamped++;
        end
        if (acc < 0) acc = 0;
        if (acc > FIELD_MAX) acc = FIELD_MAX;
        for (int i = sfir_pkg::DELAY_TAPS - 1; i > 0; i--) tap_hist[i] = tap_hist[i-1];
        tap_hist[0] = x;
        if (cmp_level == sfir_pkg::LEVEL_FLOOR) floor_items++;
        if (cmp_level == sfir_pkg::LEVEL_CEIL) ceil_items++;
        r.raw      = x;
        r.filtered = sfir_pkg::sample_t'(acc);
        r.level    = cmp_level;
        r.mode     = fir_mode;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch on result %0d: %s", results_seen, msg);
    endtask

    // driver: offers the oldest pending item, predicts on each accepted transaction
    always @(posedge aclk) begin : drive_samples
        fir_result_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                r = filter_step(s_tdata);
                fir_expected.push_back(r);
                void'(pending_items.pop_front());
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_items[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result transaction and drives m_tready
    always @(posedge aclk) begin : watch_results
        fir_result_t want;
        int stall_left;
        int stalls_taken;
        if (!aresetn) begin
            m_tready     <= 1'b0;
            stall_left   = 0;
            stalls_taken = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (fir_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, tdata %h", m_tdata));
                end else begin
                    want = fir_expected.pop_front();
                    if (m_tdata[9:0] != want.raw)
                        report_mismatch($sformatf("raw_sample got %0d, expected %0d",
                                                  m_tdata[9:0], want.raw));
                    if (m_tdata[19:10] != want.filtered)
                        report_mismatch($sformatf("filtered got %0d, expected %0d",
                                                  m_tdata[19:10], want.filtered));
                    if (m_tdata[27:20] != want.level)
                        report_mismatch($sformatf("compare_level got %0d, expected %0d",
                                                  m_tdata[27:20], want.level));
                    if (m_tuser[0] != want.mode)
                        report_mismatch($sformatf("filter_mode got %0d, expected %0d",
                                                  m_tuser[0], want.mode));
                end
            end
            if (stall_requests != stalls_taken) begin
                stalls_taken = stall_requests;
                stall_left   = STALL_LEN;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic queue_item(input int smp, input bit dn, input bit tg, input bit up);
        pending_items.push_back({3'b000, up, tg, dn, sfir_pkg::sample_t'(smp)});
    endtask

    // random items in blocks that lean toward down presses, up presses or neither, to reach both level limits
    task automatic queue_random(input int count);
        int bias;
        int dn_pct;
        int up_pct;
        int smp;
        int pick;
        bias = BIAS_NONE;
        for (int n = 0; n < count; n++) begin
            if (n % BLOCK_LEN == 0) bias = $urandom_range(2);
            case (bias)
                BIAS_DOWN: begin dn_pct = 85; up_pct = 15; end
                BIAS_UP:   begin dn_pct = 15; up_pct = 85; end
                default:   begin dn_pct = 40; up_pct = 40; end
            endcase
            pick = $urandom_range(9);
            if (pick == 0) smp = 0;
            else if (pick <= 2) smp = FIELD_MAX;
            else smp = $urandom_range(FIELD_MAX);
            queue_item(smp, $urandom_range(99) < dn_pct, $urandom_range(99) < 8,
                       $urandom_range(99) < up_pct);
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || fir_expected.size() != 0) @(negedge aclk);
    endtask

    initial begin
        clear_filter_state();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 25;
        recv_idle_pct = 86;
        // averages of extremes and press combinations from the reset history, ending with a toggle to high-pass
        queue_item(0, 0, 0, 0);
        queue_item(FIELD_MAX, 0, 0, 0);
        queue_item(FIELD_MAX, 1, 0, 0);
        queue_item(FIELD_MAX, 0, 0, 1);
        queue_item(0, 1, 0, 1);
        queue_item(512, 0, 1, 0);
        // high-pass: large middle tap drives the sum negative
        queue_item(0, 0, 0, 0);
        queue_item(0, 0, 0, 0);
        queue_item(FIELD_MAX, 0, 0, 0);
        queue_item(0, 0, 0, 0);
        queue_item(0, 0, 0, 0);
        // high-pass: zero middle tap drives the sum above full scale
        queue_item(FIELD_MAX, 0, 0, 0);
        queue_item(FIELD_MAX, 0, 0, 0);
        queue_item(0, 0, 0, 0);
        queue_item(FIELD_MAX, 0, 0, 0);
        queue_item(FIELD_MAX, 1, 0, 1);
        // all three presses at once, back to the average
        queue_item(700, 1, 1, 1);
        for (int i = 0; i < 5; i++) queue_item(FIELD_MAX, 0, 0, 0);
        queue_item(0, 1, 1, 0);
        queue_item(0, 0, 1, 1);
        queue_random(430);
        wait_drained();

        send_idle_pct = 86;
        recv_idle_pct = 25;
        queue_random(450);
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_requests++;
        queue_random(450);
        wait_drained();

        repeat (20) @(posedge aclk);
        $display("checked %0d results, %0d in high-pass mode with %0d clamped",
                 results_seen, hp_items, hp_clamped);
        $display("level held at floor for %0d items and at ceiling for %0d items",
                 floor_items, ceil_items);
        if (mismatches == 0 && fir_expected.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout with %0d results outstanding", fir_expected.size());
        $display("FAIL");
        $finish;
    end

endmodule
